// ===== rtl/core/lav_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the look-at view matrix unit.
// No dependencies; imported by lav_norm and look_at_view_matrix.
package lav_pkg;

    // width of a Q1.30 axis component
    localparam int AXIS_W = 32;

    // cycles from a vector at a normalizer input to its unit vector
    localparam int NORM_LAT = 70;

    // reset value of up_y: 1.0 in Q16.16
    localparam int UP_Y_RESET = 65536;

    localparam int CFG_IDX_W = 2;

    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_X = 2'd0,
        REG_UP_Y = 2'd1,
        REG_UP_Z = 2'd2
    } cfg_reg_t;

endpackage

// ===== rtl/core/lav_norm.sv =====
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: block scaling, bit-serial square root,
// and three restoring dividers, one result bit per stage. Uses lav_pkg.
module lav_norm #(
    parameter int IW = 33
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [IW-1:0] vec [3],
    output lav_pkg::axis_t       unit [3],
    output logic                 ok
);
    import lav_pkg::*;

    localparam int SW   = 7;     // shift amount width, covers IW up to 64
    localparam int LEAD = 29;    // scaled magnitudes keep their top one here
    localparam int RT_N = 31;    // root bits
    localparam int DV_N = 32;    // quotient bits

    // ---- stage 1: magnitudes and their OR
    logic [IW-1:0] raw_c [3];
    logic [IW-1:0] mag_c [3];
    logic [IW-1:0] ab_mag_reg [3];
    logic [2:0]    ab_neg_reg;
    logic [IW-1:0] ab_or_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            raw_c[i] = vec[i];
            mag_c[i] = raw_c[i][IW-1] ? (~raw_c[i] + 1'b1) : raw_c[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ab_mag_reg[i] <= mag_c[i];
                ab_neg_reg[i] <= raw_c[i][IW-1];
            end
            ab_or_reg <= mag_c[0] | mag_c[1] | mag_c[2];
        end
    end

    // ---- stage 2: leading one of the largest magnitude
    logic [SW-1:0] lead_c;
    logic [IW-1:0] lz_mag_reg [3];
    logic [2:0]    lz_neg_reg;
    logic          lz_zero_reg;
    logic          lz_left_reg;
    logic [SW-1:0] lz_amt_reg;

    always_comb begin
        lead_c = '0;
        for (int k = 0; k < IW; k++) begin
            if (ab_or_reg[k]) lead_c = SW'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lz_mag_reg  <= ab_mag_reg;
            lz_neg_reg  <= ab_neg_reg;
            lz_zero_reg <= ~|ab_or_reg;
            lz_left_reg <= lead_c < SW'(LEAD);
            lz_amt_reg  <= (lead_c < SW'(LEAD)) ? SW'(LEAD) - lead_c : lead_c - SW'(LEAD);
        end
    end

    // ---- stage 3: common shift into [2^29, 2^30), right shift truncates
    logic [IW+29:0] ext_c [3];
    logic [IW+29:0] sl_c [3];
    logic [IW+29:0] sr_c [3];
    logic [29:0]    sh_b_reg [3];
    logic [2:0]     sh_neg_reg;
    logic           sh_zero_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext_c[i] = {30'b0, lz_mag_reg[i]};
            sl_c[i]  = ext_c[i] << lz_amt_reg;
            sr_c[i]  = ext_c[i] >> lz_amt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sh_b_reg[i] <= lz_left_reg ? sl_c[i][29:0] : sr_c[i][29:0];
            end
            sh_neg_reg  <= lz_neg_reg;
            sh_zero_reg <= lz_zero_reg;
        end
    end

    // ---- stage 4: squares
    logic [59:0] sq_reg [3];
    logic [29:0] sq_b_reg [3];
    logic [2:0]  sq_neg_reg;
    logic        sq_zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= {30'b0, sh_b_reg[i]} * {30'b0, sh_b_reg[i]};
            end
            sq_b_reg    <= sh_b_reg;
            sq_neg_reg  <= sh_neg_reg;
            sq_zero_reg <= sh_zero_reg;
        end
    end

    // ---- square root, two radicand bits per stage; entry 0 holds the sum
    logic [32:0] rt_rem_reg  [RT_N+1];
    logic [30:0] rt_root_reg [RT_N+1];
    logic [61:0] rt_x_reg    [RT_N+1];
    logic [29:0] rt_b_reg    [RT_N+1][3];
    logic [2:0]  rt_neg_reg  [RT_N+1];
    logic        rt_zero_reg [RT_N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rt_x_reg[0]    <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_b_reg[0]    <= sq_b_reg;
            rt_neg_reg[0]  <= sq_neg_reg;
            rt_zero_reg[0] <= sq_zero_reg;
        end
    end

    for (genvar j = 1; j <= RT_N; j++) begin : g_root
        logic [34:0] r2_c;
        logic [34:0] trial_c;
        logic        ge_c;

        always_comb begin
            r2_c    = {rt_rem_reg[j-1], rt_x_reg[j-1][61:60]};
            trial_c = {2'b0, rt_root_reg[j-1], 2'b01};
            ge_c    = r2_c >= trial_c;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_rem_reg[j]  <= ge_c ? 33'(r2_c - trial_c) : r2_c[32:0];
                rt_root_reg[j] <= {rt_root_reg[j-1][29:0], ge_c};
                rt_x_reg[j]    <= {rt_x_reg[j-1][59:0], 2'b00};
                rt_b_reg[j]    <= rt_b_reg[j-1];
                rt_neg_reg[j]  <= rt_neg_reg[j-1];
                rt_zero_reg[j] <= rt_zero_reg[j-1];
            end
        end
    end

    // ---- divide: q = (b * 2^30 + len / 2) / len; entry 0 is the setup
    logic [60:0] num_c [3];
    logic [31:0] dv_rem_reg  [DV_N+1][3];
    logic [31:0] dv_n_reg    [DV_N+1][3];
    logic [31:0] dv_q_reg    [DV_N+1][3];
    logic [30:0] dv_len_reg  [DV_N+1];
    logic [2:0]  dv_neg_reg  [DV_N+1];
    logic        dv_zero_reg [DV_N+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_c[i] = 61'({rt_b_reg[RT_N][i], 30'b0}) + 61'(rt_root_reg[RT_N][30:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= {3'b0, num_c[i][60:32]};
                dv_n_reg[0][i]   <= num_c[i][31:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0]  <= rt_root_reg[RT_N];
            dv_neg_reg[0]  <= rt_neg_reg[RT_N];
            dv_zero_reg[0] <= rt_zero_reg[RT_N];
        end
    end

    for (genvar j = 1; j <= DV_N; j++) begin : g_div
        logic [31:0] t_c  [3];
        logic        ge_c [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t_c[i]  = {dv_rem_reg[j-1][i][30:0], dv_n_reg[j-1][i][31]};
                ge_c[i] = t_c[i] >= {1'b0, dv_len_reg[j-1]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[j][i] <= ge_c[i] ? t_c[i] - {1'b0, dv_len_reg[j-1]} : t_c[i];
                    dv_n_reg[j][i]   <= {dv_n_reg[j-1][i][30:0], 1'b0};
                    dv_q_reg[j][i]   <= {dv_q_reg[j-1][i][30:0], ge_c[i]};
                end
                dv_len_reg[j]  <= dv_len_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
            end
        end
    end

    // ---- output: clamp to 1.0, restore sign
    localparam logic [31:0] Q_ONE = 32'h4000_0000;
    logic [31:0] qc_c [3];
    axis_t       unit_reg [3];
    logic        ok_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qc_c[i] = (dv_q_reg[DV_N][i] > Q_ONE) ? Q_ONE : dv_q_reg[DV_N][i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                unit_reg[i] <= dv_neg_reg[DV_N][i] ? axis_t'(-qc_c[i]) : axis_t'(qc_c[i]);
            end
            ok_reg <= ~dv_zero_reg[DV_N];
        end
    end

    assign unit = unit_reg;
    assign ok   = ok_reg;

endmodule

// ===== rtl/core/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// Look-at view matrix unit: top level, config registers, cross products,
// camera-up rounding and translation. Uses lav_pkg and lav_norm.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready | s_tdata: eye xyz, target xyz
//  m_       | out       | m_tvalid/m_tready | m_tdata: right, camup, back (Q1.30), shift
//  cfg_     | in        | cfg_we            | cfg_idx, cfg_wdata: up_x/up_y/up_z
//
// One transaction per cycle sustained while m_ does not stall; the latency is set
// by two chained normalizers (root and divide, one bit per stage).
// All stages advance together; a stall on m_ freezes the whole pipeline and
// s_tready follows. Reset is synchronous; it clears the valid bits and loads
// the reset up vector.
module look_at_view_matrix #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z (low bits first)
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // right_x/y/z, camup_x/y/z, back_x/y/z, shift_x/y/z (low bits first)
    output logic [((288+3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                                  cfg_we,
    input  logic [lav_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [COORD_WIDTH-1:0]                cfg_wdata
);
    import lav_pkg::*;

    localparam int W        = COORD_WIDTH;
    localparam int OUT_BITS = 9*AXIS_W + 3*W;
    localparam int OUT_W    = ((OUT_BITS+7)/8)*8;
    localparam int EHW      = W - 15;         // integer part of a coordinate, one spare bit
    localparam int PAW      = AXIS_W + EHW;
    localparam int PBW      = AXIS_W + 17;
    localparam int AW       = PAW + 2;
    localparam int BW       = PBW + 2;
    localparam int TW       = W + 36;
    localparam int QW       = TW - 30;

    localparam logic signed [63:0]   CU_HALF = 64'sh2000_0000;
    localparam logic signed [33:0]   CU_ONE  = 34'sh0_4000_0000;
    localparam logic signed [TW-1:0] T_HALF  = TW'(64'sh2000_0000);
    localparam logic signed [QW:0]   SAT_MAX = {{(QW-W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [QW:0]   SAT_MIN = ~SAT_MAX;

    logic en;
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    // ---- configuration registers
    logic signed [W-1:0] up_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg[0] <= '0;
            up_reg[1] <= W'(UP_Y_RESET);
            up_reg[2] <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_idx))
                REG_UP_X: up_reg[0] <= cfg_wdata;
                REG_UP_Y: up_reg[1] <= cfg_wdata;
                REG_UP_Z: up_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- valid chain
    logic in_vld_reg;
    logic dl1_vld_reg [NORM_LAT];
    logic c1_vld_reg, c2_vld_reg;
    logic dl2_vld_reg [NORM_LAT];
    logic x1_vld_reg, x2_vld_reg, x3_vld_reg, x4_vld_reg, x5_vld_reg, out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            x1_vld_reg  <= 1'b0;
            x2_vld_reg  <= 1'b0;
            x3_vld_reg  <= 1'b0;
            x4_vld_reg  <= 1'b0;
            x5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < NORM_LAT; k++) begin
                dl1_vld_reg[k] <= 1'b0;
                dl2_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            in_vld_reg     <= s_tvalid;
            dl1_vld_reg[0] <= in_vld_reg;
            for (int k = 1; k < NORM_LAT; k++) dl1_vld_reg[k] <= dl1_vld_reg[k-1];
            c1_vld_reg     <= dl1_vld_reg[NORM_LAT-1];
            c2_vld_reg     <= c1_vld_reg;
            dl2_vld_reg[0] <= c2_vld_reg;
            for (int k = 1; k < NORM_LAT; k++) dl2_vld_reg[k] <= dl2_vld_reg[k-1];
            x1_vld_reg     <= dl2_vld_reg[NORM_LAT-1];
            x2_vld_reg     <= x1_vld_reg;
            x3_vld_reg     <= x2_vld_reg;
            x4_vld_reg     <= x3_vld_reg;
            x5_vld_reg     <= x4_vld_reg;
            out_vld_reg    <= x5_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;

    // ---- input stage: eye, eye - target, snapshot of up
    logic signed [W-1:0] in_eye_reg [3];
    logic signed [W:0]   in_d_reg   [3];
    logic signed [W-1:0] in_up_reg  [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                in_eye_reg[i] <= s_tdata[i*W +: W];
                in_d_reg[i]   <= (W+1)'($signed(s_tdata[i*W +: W]))
                               - (W+1)'($signed(s_tdata[(3+i)*W +: W]));
                in_up_reg[i]  <= up_reg[i];
            end
        end
    end

    // ---- back axis and normalized up
    axis_t bk_c [3];
    axis_t un_c [3];
    logic  bk_ok_c, un_ok_c;

    lav_norm #(.IW(W+1)) u_norm_back (
        .aclk (aclk),
        .en   (en),
        .vec  (in_d_reg),
        .unit (bk_c),
        .ok   (bk_ok_c)
    );

    lav_norm #(.IW(W)) u_norm_up (
        .aclk (aclk),
        .en   (en),
        .vec  (in_up_reg),
        .unit (un_c),
        .ok   (un_ok_c)
    );

    logic signed [W-1:0] dl1_eye_reg [NORM_LAT][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl1_eye_reg[0] <= in_eye_reg;
            for (int k = 1; k < NORM_LAT; k++) dl1_eye_reg[k] <= dl1_eye_reg[k-1];
        end
    end

    // ---- up x back: products, then differences
    logic signed [63:0]  c1_p_reg [6];
    axis_t               c1_bk_reg [3];
    logic signed [W-1:0] c1_eye_reg [3];
    logic                c1_ok_reg;
    logic signed [63:0]  c2_c_reg [3];
    axis_t               c2_bk_reg [3];
    logic signed [W-1:0] c2_eye_reg [3];
    logic                c2_ok_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_p_reg[0] <= 64'(un_c[1]) * 64'(bk_c[2]);
            c1_p_reg[1] <= 64'(un_c[2]) * 64'(bk_c[1]);
            c1_p_reg[2] <= 64'(un_c[2]) * 64'(bk_c[0]);
            c1_p_reg[3] <= 64'(un_c[0]) * 64'(bk_c[2]);
            c1_p_reg[4] <= 64'(un_c[0]) * 64'(bk_c[1]);
            c1_p_reg[5] <= 64'(un_c[1]) * 64'(bk_c[0]);
            c1_bk_reg   <= bk_c;
            c1_eye_reg  <= dl1_eye_reg[NORM_LAT-1];
            c1_ok_reg   <= bk_ok_c & un_ok_c;

            c2_c_reg[0] <= c1_p_reg[0] - c1_p_reg[1];
            c2_c_reg[1] <= c1_p_reg[2] - c1_p_reg[3];
            c2_c_reg[2] <= c1_p_reg[4] - c1_p_reg[5];
            c2_bk_reg   <= c1_bk_reg;
            c2_eye_reg  <= c1_eye_reg;
            c2_ok_reg   <= c1_ok_reg;
        end
    end

    // ---- right axis
    axis_t rt_c [3];
    logic  rt_ok_c;

    lav_norm #(.IW(64)) u_norm_right (
        .aclk (aclk),
        .en   (en),
        .vec  (c2_c_reg),
        .unit (rt_c),
        .ok   (rt_ok_c)
    );

    axis_t               dl2_bk_reg  [NORM_LAT][3];
    logic signed [W-1:0] dl2_eye_reg [NORM_LAT][3];
    logic                dl2_ok_reg  [NORM_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl2_bk_reg[0]  <= c2_bk_reg;
            dl2_eye_reg[0] <= c2_eye_reg;
            dl2_ok_reg[0]  <= c2_ok_reg;
            for (int k = 1; k < NORM_LAT; k++) begin
                dl2_bk_reg[k]  <= dl2_bk_reg[k-1];
                dl2_eye_reg[k] <= dl2_eye_reg[k-1];
                dl2_ok_reg[k]  <= dl2_ok_reg[k-1];
            end
        end
    end

    // ---- camera up = back x right, rounded to Q1.30 and clamped
    logic signed [63:0]  x1_p_reg [6];
    axis_t               x1_rt_reg [3];
    axis_t               x1_bk_reg [3];
    logic signed [W-1:0] x1_eye_reg [3];
    logic                x1_ok_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_p_reg[0] <= 64'(dl2_bk_reg[NORM_LAT-1][1]) * 64'(rt_c[2]);
            x1_p_reg[1] <= 64'(dl2_bk_reg[NORM_LAT-1][2]) * 64'(rt_c[1]);
            x1_p_reg[2] <= 64'(dl2_bk_reg[NORM_LAT-1][2]) * 64'(rt_c[0]);
            x1_p_reg[3] <= 64'(dl2_bk_reg[NORM_LAT-1][0]) * 64'(rt_c[2]);
            x1_p_reg[4] <= 64'(dl2_bk_reg[NORM_LAT-1][0]) * 64'(rt_c[1]);
            x1_p_reg[5] <= 64'(dl2_bk_reg[NORM_LAT-1][1]) * 64'(rt_c[0]);
            x1_rt_reg   <= rt_c;
            x1_bk_reg   <= dl2_bk_reg[NORM_LAT-1];
            x1_eye_reg  <= dl2_eye_reg[NORM_LAT-1];
            x1_ok_reg   <= dl2_ok_reg[NORM_LAT-1] & rt_ok_c;
        end
    end

    logic signed [63:0]  cd_c [3];
    logic signed [63:0]  cs_c [3];
    logic signed [33:0]  cq_c [3];
    axis_t               x2_cu_reg [3];
    axis_t               x2_rt_reg [3];
    axis_t               x2_bk_reg [3];
    logic signed [W-1:0] x2_eye_reg [3];
    logic                x2_ok_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cd_c[i] = x1_p_reg[2*i] - x1_p_reg[2*i+1];
            cs_c[i] = (cd_c[i] + CU_HALF) >>> 30;
            cq_c[i] = cs_c[i][33:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (cq_c[i] > CU_ONE) begin
                    x2_cu_reg[i] <= axis_t'(CU_ONE);
                end else if (cq_c[i] < -CU_ONE) begin
                    x2_cu_reg[i] <= axis_t'(-CU_ONE);
                end else begin
                    x2_cu_reg[i] <= axis_t'(cq_c[i]);
                end
            end
            x2_rt_reg  <= x1_rt_reg;
            x2_bk_reg  <= x1_bk_reg;
            x2_eye_reg <= x1_eye_reg;
            x2_ok_reg  <= x1_ok_reg;
        end
    end

    // ---- translation: eye split into integer and fraction parts
    // row 0 right, row 1 camera up, row 2 back
    axis_t                 ax_c [3][3];
    logic signed [EHW-1:0] eh_c [3];
    logic signed [16:0]    el_c [3];
    logic signed [PAW-1:0] x3_pa_reg [3][3];
    logic signed [PBW-1:0] x3_pb_reg [3][3];
    axis_t                 x3_ax_reg [3][3];
    logic                  x3_ok_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ax_c[0][i] = x2_rt_reg[i];
            ax_c[1][i] = x2_cu_reg[i];
            ax_c[2][i] = x2_bk_reg[i];
            eh_c[i]    = EHW'(x2_eye_reg[i] >>> 16);
            el_c[i]    = $signed({1'b0, x2_eye_reg[i][15:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    x3_pa_reg[r][i] <= PAW'(ax_c[r][i]) * PAW'(eh_c[i]);
                    x3_pb_reg[r][i] <= PBW'(ax_c[r][i]) * PBW'(el_c[i]);
                end
            end
            x3_ax_reg <= ax_c;
            x3_ok_reg <= x2_ok_reg;
        end
    end

    logic signed [AW-1:0] x4_a_reg [3];
    logic signed [BW-1:0] x4_b_reg [3];
    axis_t                x4_ax_reg [3][3];
    logic                 x4_ok_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                x4_a_reg[r] <= AW'(x3_pa_reg[r][0]) + AW'(x3_pa_reg[r][1])
                             + AW'(x3_pa_reg[r][2]);
                x4_b_reg[r] <= BW'(x3_pb_reg[r][0]) + BW'(x3_pb_reg[r][1])
                             + BW'(x3_pb_reg[r][2]);
            end
            x4_ax_reg <= x3_ax_reg;
            x4_ok_reg <= x3_ok_reg;
        end
    end

    // sum in Q.46, round half up to Q.16
    logic signed [TW-1:0] t_c [3];
    logic signed [TW-1:0] ts_c [3];
    logic signed [QW-1:0] x5_q_reg [3];
    axis_t                x5_ax_reg [3][3];
    logic                 x5_ok_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            t_c[r]  = (TW'(x4_a_reg[r]) <<< 16) + TW'(x4_b_reg[r]) + T_HALF;
            ts_c[r] = t_c[r] >>> 30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) x5_q_reg[r] <= ts_c[r][QW-1:0];
            x5_ax_reg <= x4_ax_reg;
            x5_ok_reg <= x4_ok_reg;
        end
    end

    // ---- output register: negate, saturate, zero on degenerate input
    logic signed [QW:0]    nq_c [3];
    logic signed [W-1:0]   sat_c [3];
    logic [OUT_BITS-1:0]   pack_c;
    logic [OUT_BITS-1:0]   out_data_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nq_c[r] = -((QW+1)'(x5_q_reg[r]));
            if (nq_c[r] > SAT_MAX) begin
                sat_c[r] = SAT_MAX[W-1:0];
            end else if (nq_c[r] < SAT_MIN) begin
                sat_c[r] = SAT_MIN[W-1:0];
            end else begin
                sat_c[r] = nq_c[r][W-1:0];
            end
        end
        pack_c = '0;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                pack_c[(3*r+i)*AXIS_W +: AXIS_W] = x5_ax_reg[r][i];
            end
            pack_c[9*AXIS_W + r*W +: W] = sat_c[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= x5_ok_reg ? pack_c : '0;
        end
    end

    assign m_tdata = OUT_W'(out_data_reg);

endmodule

// ===== bench/look_at_view_matrix_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix: random and directed eye/target
// transactions against an in-bench fixed-point look-at predictor. Uses lav_pkg.
module look_at_view_matrix_test;
    import lav_pkg::*;

    localparam int CW = 32;
    localparam int IN_W = ((6*CW+7)/8)*8;
    localparam int OUT_W = ((288+3*CW+7)/8)*8;
    localparam int LAT = 2*NORM_LAT + 9;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t sz, sy, sx;
        axis_t bz, by, bx;
        axis_t uz, uy, ux;
        axis_t rz, ry, rx;
    } view_t;

    // fixed-point look-at predictor plus queue of pending view matrices
    class view_scoreboard;
        longint up[3];
        view_t pending[$];
        int errors;
        int checked;

        function new();
            up[0] = 0; up[1] = UP_Y_RESET; up[2] = 0;
            errors = 0; checked = 0;
        endfunction

        function longint floor_shr(longint x, int k);
            return x >>> k;
        endfunction

        function longint int_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit unit_vec(input longint v[3], output longint o[3]);
            longint unsigned a[3], m, s, len, q;
            bit ng[3];
            m = 0; s = 0;
            for (int i = 0; i < 3; i++) begin
                ng[i] = v[i] < 0;
                a[i] = ng[i] ? -v[i] : v[i];
                if (a[i] > m) m = a[i];
            end
            if (m == 0) return 0;
            while (m >= (64'd1 << 30)) begin
                m >>= 1;
                for (int i = 0; i < 3; i++) a[i] >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) a[i] <<= 1;
            end
            for (int i = 0; i < 3; i++) s += a[i] * a[i];
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = ((a[i] << 30) + len / 2) / len;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
                o[i] = ng[i] ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        // minus dot(axis, eye), split to stay inside 64 bits
        function longint shift_of(input longint ax[3], input longint e[3]);
            longint hi, lo, res, lim;
            hi = 0; lo = 0;
            for (int i = 0; i < 3; i++) begin
                hi += ax[i] * floor_shr(e[i], 16);
                lo += ax[i] * (e[i] & 64'hFFFF);
            end
            res = -(floor_shr(hi, 14) + floor_shr((hi & 64'h3FFF) * 65536 + lo
                  + (64'd1 << 29), 30));
            lim = 64'd1 << (CW-1);
            if (res > lim - 1) res = lim - 1;
            if (res < -lim) res = -lim;
            return res;
        endfunction

        function void set_reg(cfg_reg_t idx, coord_t val);
            up[int'(idx)] = longint'(val);
        endfunction

        function void note_input(coord_t eye[3], coord_t tgt[3]);
            longint e[3], d[3], bk[3], un[3], c[3], rt[3], cu[3], q;
            view_t vw;
            vw = '0;
            for (int i = 0; i < 3; i++) begin
                e[i] = longint'(eye[i]);
                d[i] = e[i] - longint'(tgt[i]);
            end
            if (unit_vec(d, bk) && unit_vec(up, un)) begin
                c[0] = un[1]*bk[2] - un[2]*bk[1];
                c[1] = un[2]*bk[0] - un[0]*bk[2];
                c[2] = un[0]*bk[1] - un[1]*bk[0];
                if (unit_vec(c, rt)) begin
                    c[0] = bk[1]*rt[2] - bk[2]*rt[1];
                    c[1] = bk[2]*rt[0] - bk[0]*rt[2];
                    c[2] = bk[0]*rt[1] - bk[1]*rt[0];
                    for (int i = 0; i < 3; i++) begin
                        q = floor_shr(c[i] + (64'sd1 << 29), 30);
                        if (q > (64'sd1 << 30)) q = 64'sd1 << 30;
                        if (q < -(64'sd1 << 30)) q = -(64'sd1 << 30);
                        cu[i] = q;
                    end
                    vw.rx = axis_t'(rt[0]); vw.ry = axis_t'(rt[1]); vw.rz = axis_t'(rt[2]);
                    vw.ux = axis_t'(cu[0]); vw.uy = axis_t'(cu[1]); vw.uz = axis_t'(cu[2]);
                    vw.bx = axis_t'(bk[0]); vw.by = axis_t'(bk[1]); vw.bz = axis_t'(bk[2]);
                    vw.sx = coord_t'(shift_of(rt, e));
                    vw.sy = coord_t'(shift_of(cu, e));
                    vw.sz = coord_t'(shift_of(bk, e));
                end
            end
            pending.push_back(vw);
        endfunction

        function void report(string nm, longint ex, longint ac);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, ex, ac);
            errors++;
        endfunction

        function void check_result(view_t got);
            view_t ex;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
                return;
            end
            ex = pending.pop_front();
            checked++;
            if (got.rx !== ex.rx) report("right_x", ex.rx, got.rx);
            if (got.ry !== ex.ry) report("right_y", ex.ry, got.ry);
            if (got.rz !== ex.rz) report("right_z", ex.rz, got.rz);
            if (got.ux !== ex.ux) report("camup_x", ex.ux, got.ux);
            if (got.uy !== ex.uy) report("camup_y", ex.uy, got.uy);
            if (got.uz !== ex.uz) report("camup_z", ex.uz, got.uz);
            if (got.bx !== ex.bx) report("back_x", ex.bx, got.bx);
            if (got.by !== ex.by) report("back_y", ex.by, got.by);
            if (got.bz !== ex.bz) report("back_z", ex.bz, got.bz);
            if (got.sx !== ex.sx) report("shift_x", ex.sx, got.sx);
            if (got.sy !== ex.sy) report("shift_y", ex.sy, got.sy);
            if (got.sz !== ex.sz) report("shift_z", ex.sz, got.sz);
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
    logic [IN_W-1:0] s_tdata;
    logic [OUT_W-1:0] m_tdata;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CW-1:0] cfg_wdata;

    view_scoreboard sb;
    longint cycles;
    int n_items;
    bit rx_stall_on;

    look_at_view_matrix #(.COORD_WIDTH(CW)) dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
            1: return coord_t'($signed($urandom_range(0, 400)) - 200);
            2: return coord_t'(($signed($urandom_range(0, 200)) - 100) <<< 16);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_item(coord_t eye[3], coord_t tgt[3]);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= {tgt[2], tgt[1], tgt[0], eye[2], eye[1], eye[0]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(eye, tgt);
        n_items++;
    endtask

    task automatic write_reg(cfg_reg_t idx, coord_t val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    task automatic set_up(coord_t x, coord_t y, coord_t z);
        drain();
        write_reg(REG_UP_X, x);
        write_reg(REG_UP_Y, y);
        write_reg(REG_UP_Z, z);
        cfg_we <= 1'b0;
    endtask

    // result side: random stall while rx_stall_on is set, sample at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(view_t'(m_tdata));
            m_tready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        coord_t eye[3], tgt[3];
        sb = new();
        cycles = 0; n_items = 0; rx_stall_on = 1;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
        cfg_we = 0; cfg_idx = REG_UP_X; cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset up vector, degenerate and extreme points
        eye = '{0, 0, 0}; tgt = '{0, 0, 0}; send_item(eye, tgt);           // eye == target
        eye = '{0, 32'sh10000, 0}; tgt = '{0, 0, 0}; send_item(eye, tgt);  // back parallel to up
        eye = '{32'sh30000, 32'sh20000, 32'sh50000}; tgt = '{0, 0, 0}; send_item(eye, tgt);
        eye = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        tgt = '{32'h80000000, 32'h80000000, 32'h80000000}; send_item(eye, tgt);
        eye = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        tgt = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}; send_item(eye, tgt);
        eye = '{1, 0, 0}; tgt = '{0, 0, 0}; send_item(eye, tgt);
        eye = '{32'h7FFFFFFF, 32'h80000000, 1}; tgt = '{0, 0, 0}; send_item(eye, tgt);
        eye = '{0, 0, 32'h80000000}; tgt = '{0, 0, 32'h7FFFFFFF}; send_item(eye, tgt);
        // zero up vector
        set_up(0, 0, 0);
        eye = '{32'sh10000, 0, 0}; tgt = '{0, 0, 0}; send_item(eye, tgt);
        // extreme up vectors
        set_up(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        eye = '{32'sh10000, 32'sh20000, 0}; tgt = '{0, 0, 32'sh10000}; send_item(eye, tgt);
        eye = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        tgt = '{0, 0, 0}; send_item(eye, tgt);                              // parallel to up
        set_up(1, 0, 0);
        eye = '{5, 7, 32'h7FFFFFFF}; tgt = '{32'h80000000, 0, 0}; send_item(eye, tgt);

        // random phases, each with an up vector written anew
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 3)
                0: set_up(rnd_coord(), rnd_coord(), rnd_coord());
                1: set_up(0, 32'sh10000, 0);
                default: set_up(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
            endcase
            rx_stall_on = (ph % 4 != 3);
            for (int k = 0; k < 110; k++) begin
                for (int i = 0; i < 3; i++) begin
                    eye[i] = rnd_coord();
                    tgt[i] = ($urandom_range(0, 19) == 0) ? eye[i] : rnd_coord();
                end
                // sometimes line the view up with the up vector
                if ($urandom_range(0, 29) == 0)
                    for (int i = 0; i < 3; i++) tgt[i] = eye[i] - coord_t'(sb.up[i]);
                send_item(eye, tgt);
            end
        end

        drain();
        $display("covered %0d transactions, %0d results checked, 14 up-vector settings",
                 n_items, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
